@@ src/ils_pkg.sv @@
// shared types and constants for the interval latency statistics block
package ils_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = 3;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TICK_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int HALF_W     = TICK_W / 2;
   localparam int NUM_W      = TICK_W + COUNT_W;
   localparam int DIV_CNT_W  = $clog2(TICK_W);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_END   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TICK_W-1:0]  average;
      logic [TICK_W-1:0]  addend;
   } avg_req_type;

endpackage

@@ src/ils_avg_unit.sv @@
// shared multiply and radix-2 divide unit for the cumulative average
module ils_avg_unit import ils_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  avg_req_type       req,
   output logic              done,
   output logic [TICK_W-1:0] quotient
);

   typedef enum logic [1:0] {
      U_IDLE,
      U_MUL_LO,
      U_MUL_HI,
      U_DIV
   } ustate_type;

   ustate_type             ustate_ff;
   logic                   done_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [COUNT_W-1:0]     n_ff;
   logic [TICK_W-1:0]      avg_ff;
   logic [TICK_W-1:0]      add_ff;
   logic [COUNT_W:0]       div_ff;
   logic [COUNT_W:0]       rem_ff;
   logic [TICK_W-1:0]      num_ff;

   logic [HALF_W-1:0]      mul_a;
   logic [TICK_W-1:0]      prod;
   logic [NUM_W-1:0]       acc;
   logic [NUM_W-1:0]       lo_sum;
   logic [NUM_W-1:0]       hi_sum;
   logic [COUNT_W+1:0]     part;
   logic [COUNT_W+1:0]     diff;

   always_comb begin
      mul_a  = (ustate_ff == U_MUL_LO) ? avg_ff[HALF_W-1:0] : avg_ff[TICK_W-1:HALF_W];
      prod   = TICK_W'(mul_a) * TICK_W'(n_ff);
      acc    = {rem_ff[COUNT_W-1:0], num_ff};
      lo_sum = NUM_W'(prod) + NUM_W'(add_ff);
      hi_sum = acc + {prod, {HALF_W{1'b0}}};
      part   = {rem_ff, num_ff[TICK_W-1]};
      diff   = part - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= (ustate_ff == U_DIV) && (cnt_ff == '1);
         case (ustate_ff)
            U_IDLE: begin
               if (start) begin
                  n_ff      <= req.count;
                  avg_ff    <= req.average;
                  add_ff    <= req.addend;
                  div_ff    <= (COUNT_W+1)'(req.count) + 1'b1;
                  ustate_ff <= U_MUL_LO;
               end
            end
            U_MUL_LO: begin
               rem_ff    <= {1'b0, lo_sum[NUM_W-1:TICK_W]};
               num_ff    <= lo_sum[TICK_W-1:0];
               ustate_ff <= U_MUL_HI;
            end
            U_MUL_HI: begin
               rem_ff    <= {1'b0, hi_sum[NUM_W-1:TICK_W]};
               num_ff    <= hi_sum[TICK_W-1:0];
               cnt_ff    <= '0;
               ustate_ff <= U_DIV;
            end
            U_DIV: begin
               rem_ff <= diff[COUNT_W+1] ? part[COUNT_W:0] : diff[COUNT_W:0];
               num_ff <= {num_ff[TICK_W-2:0], ~diff[COUNT_W+1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '1) begin
                  ustate_ff <= U_IDLE;
               end
            end
            default: ustate_ff <= U_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

@@ src/interval_latency_statistics.sv @@
// top level: slot table, item sequencer and result register
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   opcode, slot, now_tick
//   rsp      out        rsp_valid/rsp_stall   average, maximum, count, armed, interval, ignored
//
// start, clear, read, and an end that leaves the average: result registered after the exec and done states
// an end that updates the average: the item also waits in the wait state for the shared
// 32x32 multiplier, run on the low and then the high half, and the 64-step radix-2 divider
// one item at a time; the next item is taken once the result is in the output register
// a stalled result holds the block in its final state until the register frees
// synchronous reset clears every slot at once
module interval_latency_statistics import ils_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [TICK_W-1:0]  req_now_tick,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [TICK_W-1:0]  rsp_slot_average,
   output logic [TICK_W-1:0]  rsp_slot_maximum,
   output logic [COUNT_W-1:0] rsp_slot_count,
   output logic               rsp_slot_armed,
   output logic [TICK_W-1:0]  rsp_interval,
   output logic               rsp_end_ignored
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type            state_ff;
   op_type               op_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [TICK_W-1:0]    tick_ff;
   logic [TICK_W-1:0]    el_ff;

   logic                 armed_ff [SLOT_COUNT];
   logic [TICK_W-1:0]    start_ff [SLOT_COUNT];
   logic [COUNT_W-1:0]   count_ff [SLOT_COUNT];
   logic [TICK_W-1:0]    avg_ff   [SLOT_COUNT];
   logic [TICK_W-1:0]    max_ff   [SLOT_COUNT];

   logic                 rsp_valid_ff;
   logic [TICK_W-1:0]    rsp_avg_ff;
   logic [TICK_W-1:0]    rsp_max_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_armed_ff;
   logic [TICK_W-1:0]    rsp_interval_ff;
   logic                 rsp_ignored_ff;

   logic                 in_range;
   logic [SLOT_IDX_W-1:0] idx;
   logic                 cur_armed;
   logic [TICK_W-1:0]    cur_start;
   logic [COUNT_W-1:0]   cur_count;
   logic [TICK_W-1:0]    cur_avg;
   logic [TICK_W-1:0]    cur_max;
   logic                 sat;
   logic [TICK_W-1:0]    el_in;

   logic                 nx_armed;
   logic [TICK_W-1:0]    nx_start;
   logic [COUNT_W-1:0]   nx_count;
   logic [TICK_W-1:0]    nx_avg;
   logic [TICK_W-1:0]    nx_max;
   logic [TICK_W-1:0]    nx_interval;
   logic                 nx_ignored;

   logic                 req_accept;
   logic                 rsp_free;
   logic                 avg_start;
   avg_req_type          avg_req;
   logic                 avg_done;
   logic [TICK_W-1:0]    avg_quo;

   ils_avg_unit u_avg (
      .clock    (clock),
      .reset    (reset),
      .start    (avg_start),
      .req      (avg_req),
      .done     (avg_done),
      .quotient (avg_quo)
   );

   always_comb begin
      in_range  = (32'(slot_ff) < 32'(SLOT_COUNT));
      idx       = SLOT_IDX_W'(slot_ff);
      cur_armed = in_range ? armed_ff[idx] : 1'b0;
      cur_start = in_range ? start_ff[idx] : '0;
      cur_count = in_range ? count_ff[idx] : '0;
      cur_avg   = in_range ? avg_ff[idx]   : '0;
      cur_max   = in_range ? max_ff[idx]   : '0;
      sat       = (cur_count == '1);
      el_in     = tick_ff - cur_start;

      req_accept = req_valid && !req_stall;
      rsp_free   = !rsp_valid_ff || !rsp_stall;

      avg_start       = (state_ff == ST_EXEC) && in_range && (op_ff == OP_END)
                        && cur_armed && !sat;
      avg_req.count   = cur_count;
      avg_req.average = cur_avg;
      avg_req.addend  = el_in;
   end

   always_comb begin
      nx_armed    = cur_armed;
      nx_start    = cur_start;
      nx_count    = cur_count;
      nx_avg      = cur_avg;
      nx_max      = cur_max;
      nx_interval = '0;
      nx_ignored  = 1'b0;
      if (in_range) begin
         case (op_ff)
            OP_START: begin
               nx_armed = 1'b1;
               nx_start = tick_ff;
            end
            OP_END: begin
               if (cur_armed) begin
                  nx_interval = el_ff;
                  if (!sat) begin
                     nx_avg   = avg_quo;
                     nx_count = cur_count + 1'b1;
                  end
                  if (el_ff > cur_max) begin
                     nx_max = el_ff;
                  end
               end else begin
                  nx_ignored = 1'b1;
               end
            end
            OP_CLEAR: begin
               nx_armed = 1'b0;
               nx_start = '0;
               nx_count = '0;
               nx_avg   = '0;
               nx_max   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            armed_ff[i] <= 1'b0;
            start_ff[i] <= '0;
            count_ff[i] <= '0;
            avg_ff[i]   <= '0;
            max_ff[i]   <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  op_ff    <= op_type'(req_opcode);
                  slot_ff  <= req_slot;
                  tick_ff  <= req_now_tick;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               el_ff    <= el_in;
               state_ff <= avg_start ? ST_WAIT : ST_DONE;
            end
            ST_WAIT: begin
               if (avg_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  if (in_range) begin
                     armed_ff[idx] <= nx_armed;
                     start_ff[idx] <= nx_start;
                     count_ff[idx] <= nx_count;
                     avg_ff[idx]   <= nx_avg;
                     max_ff[idx]   <= nx_max;
                  end
                  rsp_valid_ff    <= 1'b1;
                  rsp_avg_ff      <= nx_avg;
                  rsp_max_ff      <= nx_max;
                  rsp_count_ff    <= nx_count;
                  rsp_armed_ff    <= nx_armed;
                  rsp_interval_ff <= nx_interval;
                  rsp_ignored_ff  <= nx_ignored;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_average = rsp_avg_ff;
   assign rsp_slot_maximum = rsp_max_ff;
   assign rsp_slot_count   = rsp_count_ff;
   assign rsp_slot_armed   = rsp_armed_ff;
   assign rsp_interval     = rsp_interval_ff;
   assign rsp_end_ignored  = rsp_ignored_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      avg_done |-> state_ff == ST_WAIT)
      else $error("divider finished outside the wait state");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted item did not start execution");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without finishing an item");

   a_ignored_no_interval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ignored_ff |-> rsp_interval_ff == '0)
      else $error("ignored end item reported an interval");

endmodule
